// File: rtl/core/adec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adec_pkg
// Shared types, constants and tables of the 4-bit ADPCM nibble decoder.
// ----------------------------------------------------------------------------
package adec_pkg;

    // decoder state: 12-bit predictor and step table index
    typedef struct packed {
        logic signed [11:0] pred;
        logic [5:0]         idx;
    } state_t;

    localparam logic signed [11:0] PRED_MAX     = 12'sd2047;
    localparam logic signed [11:0] PRED_MIN     = -12'sd2048;
    localparam logic signed [11:0] PRED_RESTART = -12'sd2;
    localparam logic [5:0]         IDX_MAX      = 6'd48;

    localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

    // configuration register map
    localparam int unsigned ADDR_W     = 3;
    localparam logic        REG_VOLUME = 1'b0;
    localparam logic [8:0]  VOL_RESET  = 9'd255;

    // step size table, floor(16 * 1.1^n)
    function automatic logic [10:0] step_size(input logic [5:0] idx);
        logic [10:0] s;
        begin
            case (idx)
                6'd0:  s = 11'd16;
                6'd1:  s = 11'd17;
                6'd2:  s = 11'd19;
                6'd3:  s = 11'd21;
                6'd4:  s = 11'd23;
                6'd5:  s = 11'd25;
                6'd6:  s = 11'd28;
                6'd7:  s = 11'd31;
                6'd8:  s = 11'd34;
                6'd9:  s = 11'd37;
                6'd10: s = 11'd41;
                6'd11: s = 11'd45;
                6'd12: s = 11'd50;
                6'd13: s = 11'd55;
                6'd14: s = 11'd60;
                6'd15: s = 11'd66;
                6'd16: s = 11'd73;
                6'd17: s = 11'd80;
                6'd18: s = 11'd88;
                6'd19: s = 11'd97;
                6'd20: s = 11'd107;
                6'd21: s = 11'd118;
                6'd22: s = 11'd130;
                6'd23: s = 11'd143;
                6'd24: s = 11'd157;
                6'd25: s = 11'd173;
                6'd26: s = 11'd190;
                6'd27: s = 11'd209;
                6'd28: s = 11'd230;
                6'd29: s = 11'd253;
                6'd30: s = 11'd279;
                6'd31: s = 11'd307;
                6'd32: s = 11'd337;
                6'd33: s = 11'd371;
                6'd34: s = 11'd408;
                6'd35: s = 11'd449;
                6'd36: s = 11'd494;
                6'd37: s = 11'd544;
                6'd38: s = 11'd598;
                6'd39: s = 11'd658;
                6'd40: s = 11'd724;
                6'd41: s = 11'd796;
                6'd42: s = 11'd876;
                6'd43: s = 11'd963;
                6'd44: s = 11'd1060;
                6'd45: s = 11'd1166;
                6'd46: s = 11'd1282;
                6'd47: s = 11'd1411;
                default: s = 11'd1552;
            endcase
            return s;
        end
    endfunction

    // index adjustment by code magnitude
    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] m;
        begin
            case (mag)
                3'd4:    m = 5'sd2;
                3'd5:    m = 5'sd4;
                3'd6:    m = 5'sd6;
                3'd7:    m = 5'sd8;
                default: m = -5'sd1;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/adpcm_nibble_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adpcm_nibble_decoder
// 4-bit ADPCM decoder with 12-bit predictor and volume-scaled 16-bit output.
//
// Input channel: code_valid/code_stall carry one nibble (code) and a restart
// flag per beat. Output channel: sample_valid/sample_stall carry one signed
// 16-bit sample_out per input beat, in order. The APB port writes the 9-bit
// volume register (byte address 0, 256 is unity gain).
// A beat accepted at a clock edge updates predictor and step index at that
// edge; its sample is then scaled from the new predictor and registered in
// the output register. One beat per cycle is sustained while the receiver
// does not stall; state update and scaling multiply overlap as two stages.
// Reset sets the predictor to -2, the step index to 0 and the volume to 255,
// and empties both stages. When the receiver stalls, the output register
// holds its sample; one more beat is taken into the first stage, after which
// code_stall rises until the output drains.
// ----------------------------------------------------------------------------
module adpcm_nibble_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        code_valid,
    output logic                        code_stall,
    input  logic [3:0]                  code,
    input  logic                        restart,
    output logic                        sample_valid,
    input  logic                        sample_stall,
    output logic signed [15:0]          sample_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [adec_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import adec_pkg::*;

    logic               accept;
    logic               out_ready;
    logic [8:0]         volume;
    state_t             state_reg;
    state_t             state_next;
    state_t             step_result;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [15:0] scaled;
    logic signed [15:0] sample_reg;

    adec_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .volume  (volume)
    );

    adec_step u_step (
        .state_cur  (state_reg),
        .code       (code),
        .restart    (restart),
        .state_next (step_result)
    );

    adec_scale u_scale (
        .pred   (state_reg.pred),
        .volume (volume),
        .sample (scaled)
    );

    // pipeline flow control
    always_comb
    begin
        out_ready      = !out_valid_reg || !sample_stall;
        code_stall     = s1_valid_reg && !out_ready;
        accept         = code_valid && !code_stall;
        state_next     = accept ? step_result : state_reg;
        s1_valid_next  = accept || (s1_valid_reg && !out_ready);
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    // decoder state and stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pred <= PRED_RESTART;
            state_reg.idx  <= 6'd0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output sample register
    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
            sample_reg <= scaled;
    end

    assign sample_valid = out_valid_reg;
    assign sample_out   = sample_reg;

endmodule
`default_nettype wire

// File: rtl/core/adec_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adec_step
// Next-state logic: step lookup, difference, predictor and index clamping.
// ----------------------------------------------------------------------------
module adec_step (
    input  adec_pkg::state_t state_cur,
    input  logic [3:0]       code,
    input  logic             restart,
    output adec_pkg::state_t state_next
);
    import adec_pkg::*;

    logic signed [11:0] pred_base;
    logic [5:0]         idx_base;
    logic [10:0]        step;
    logic [11:0]        diff;
    logic signed [13:0] diff_s;
    logic signed [13:0] sig;
    logic signed [6:0]  idx_sum;

    // restart takes effect before the code is decoded
    always_comb
    begin
        pred_base = restart ? PRED_RESTART : state_cur.pred;
        idx_base  = restart ? 6'd0 : state_cur.idx;
        step      = step_size(idx_base);
    end

    // difference from the magnitude bits, then the sign bit
    always_comb
    begin
        diff = {4'd0, step[10:3]};
        if (code[2])
            diff = diff + {1'b0, step};
        if (code[1])
            diff = diff + {2'd0, step[10:1]};
        if (code[0])
            diff = diff + {3'd0, step[10:2]};
        diff_s = $signed({2'b00, diff});
        sig    = 14'(pred_base) + (code[3] ? -diff_s : diff_s);
    end

    // saturate predictor
    always_comb
    begin
        if (sig > 14'(PRED_MAX))
            state_next.pred = PRED_MAX;
        else if (sig < 14'(PRED_MIN))
            state_next.pred = PRED_MIN;
        else
            state_next.pred = sig[11:0];
    end

    // move and clamp step index
    always_comb
    begin
        idx_sum = $signed({1'b0, idx_base}) + 7'(index_move(code[2:0]));
        if (idx_sum > $signed({1'b0, IDX_MAX}))
            state_next.idx = IDX_MAX;
        else if (idx_sum < 7'sd0)
            state_next.idx = 6'd0;
        else
            state_next.idx = idx_sum[5:0];
    end

endmodule
`default_nettype wire

// File: rtl/core/adec_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adec_scale
// Volume scaling: predictor times volume, arithmetic shift by four, saturate.
// ----------------------------------------------------------------------------
module adec_scale (
    input  logic signed [11:0] pred,
    input  logic [8:0]         volume,
    output logic signed [15:0] sample
);
    import adec_pkg::*;

    logic signed [21:0] prod;
    logic signed [17:0] shifted;

    // 12x10 signed multiply, drop four fraction bits
    always_comb
    begin
        prod    = pred * $signed({1'b0, volume});
        shifted = prod[21:4];
    end

    // clip to 16 bits, only reachable for volume above unity
    always_comb
    begin
        if (shifted > 18'(SAMPLE_MAX))
            sample = SAMPLE_MAX;
        else if (shifted < 18'(SAMPLE_MIN))
            sample = SAMPLE_MIN;
        else
            sample = shifted[15:0];
    end

endmodule
`default_nettype wire

// File: rtl/core/adec_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adec_cfg
// APB register block holding the volume register.
// ----------------------------------------------------------------------------
module adec_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [adec_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [8:0]                  volume
);
    import adec_pkg::*;

    logic       wr_en;
    logic [8:0] volume_reg;
    logic [8:0] volume_next;

    assign pready = 1'b1;

    // write decode, register index from word address
    always_comb
    begin
        wr_en       = psel && penable && pwrite && pready;
        volume_next = volume_reg;
        unique case (paddr[2])
            REG_VOLUME:
                if (wr_en)
                    volume_next = pwdata[8:0];
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            volume_reg <= VOL_RESET;
        else
            volume_reg <= volume_next;
    end

    // read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_VOLUME: prdata = {23'd0, volume_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign volume = volume_reg;

endmodule
`default_nettype wire

// File: rtl/core/adec_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adec_checker
// Port-level checks of the ADPCM decoder channels, bound to the top level.
// ----------------------------------------------------------------------------
module adec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        code_valid,
    input logic        code_stall,
    input logic        sample_valid,
    input logic        sample_stall,
    input logic [15:0] sample_out
);

    // a stalled output beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> sample_valid)
    else $error("output beat dropped while stalled");

    // a stalled output beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_stall |=> $stable(sample_out))
    else $error("output payload changed while stalled");

    // the input backs up only behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |-> sample_valid && sample_stall)
    else $error("input stalled without output back-pressure");

    // a new output beat is preceded by an accepted input beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid) |-> $past(code_valid && !code_stall, 2))
    else $error("output beat without a matching input beat");

endmodule

bind adpcm_nibble_decoder adec_checker u_adec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_out   (sample_out)
);
`default_nettype wire
